// ===== hw/rtl/chunk_response_stream_checker_macros.svh =====
// Assertion macros used by the checker's sequencer RTL.
`ifndef CHUNK_RESPONSE_STREAM_CHECKER_MACROS_SVH
`define CHUNK_RESPONSE_STREAM_CHECKER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CRSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CRSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/crsc_pkg.sv =====
// Package with types and constants of the chunk response stream checker.
`timescale 1ns / 1ps
package crsc_pkg;
  localparam int unsigned HdrBytes   = 98;
  localparam int unsigned ShiftBytes = 34;
  localparam int unsigned RootAt     = 66;
  localparam logic [7:0]  Magic0 = 8'h4C;
  localparam logic [7:0]  Magic1 = 8'h58;
  localparam logic [7:0]  Magic2 = 8'h44;
  localparam logic [7:0]  Magic3 = 8'h52;
  localparam logic [7:0]  Version = 8'h01;
  localparam logic [24:0] SumMax  = 25'h1FFFFFF;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StHeader  = 2'd1,
    StLength  = 2'd2,
    StSequence = 2'd3
  } status_e;

  // Per-frame summary handed from the parser to the sequence stage.
  typedef struct packed {
    logic        hdr_bad;    // short or bad magic/version
    logic        len_bad;    // length field or frame size wrong
    logic        root_bad;   // root differs from bundle root
    logic [63:0] batch;
    logic [31:0] idx;
    logic [31:0] cnt;
    logic [7:0]  cls;
    logic [63:0] offs;
    logic [16:0] plen;
  } frame_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] idx;
    logic [31:0] cnt;
    logic [63:0] batch;
    logic [7:0]  cls;
    logic [63:0] offs;
    logic [16:0] plen;
    logic        complete;
    logic [24:0] sum;
  } result_t;
endpackage

// ===== hw/rtl/chunk_response_stream_checker.sv =====
// Top level of the chunk response stream checker.
`timescale 1ns / 1ps
// Accepts one response byte per cycle, back to back, unless held for a
// waiting frame summary, and gives one result transaction per response
// after its last byte. A parser front end captures the 98-byte big-endian
// header and checks magic, version, root and frame size; it hands a frame
// summary through a one-entry register to the sequence checker, which tests
// index, count and batch against the bundle in progress and registers the
// result; either side may stall while the other continues. While a frame
// summary waits, the next frame is held, and its root bytes also wait in the
// cycle the summary is taken, so its root is judged against the bundle state
// that frame will actually meet. Configuration is written by a plain write
// port: index 0 match_batch_enable, index 1 wanted_batch.
module chunk_response_stream_checker #(
  parameter int unsigned MAX_CHUNK_BYTES = 65536,
  parameter int unsigned MAX_CHUNKS      = 256,
  parameter int unsigned CLASS_COUNT     = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] chunk_number_o,
  output logic [31:0] chunk_total_o,
  output logic [63:0] batch_id_o,
  output logic [7:0]  data_class_o,
  output logic [63:0] offset_in_class_o,
  output logic [16:0] payload_length_o,
  output logic        bundle_complete_o,
  output logic [24:0] bundle_bytes_o
);
  logic              match_q;
  logic [63:0]       wanted_q;
  logic              fr_valid, fr_ready, first_exp;
  crsc_pkg::frame_t  fr;
  crsc_pkg::result_t res;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      wanted_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'b0) match_q <= cfg_data_i[0];
      else wanted_q <= cfg_data_i;
    end
  end

  crsc_parser #(.MaxChunkBytes(MAX_CHUNK_BYTES)) u_parser (
    .clk_i, .rst_ni,
    .byte_valid_i(in_valid_i), .byte_ready_o(in_ready_o),
    .data_byte_i, .last_byte_i,
    .first_expected_i(first_exp),
    .frame_valid_o(fr_valid), .frame_ready_i(fr_ready), .frame_o(fr)
  );

  crsc_sequencer #(.MaxChunks(MAX_CHUNKS), .ClassCount(CLASS_COUNT)) u_seq (
    .clk_i, .rst_ni,
    .match_en_i(match_q), .wanted_i(wanted_q),
    .frame_valid_i(fr_valid), .frame_ready_o(fr_ready), .frame_i(fr),
    .first_expected_o(first_exp),
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .res_o(res)
  );

  assign status_o          = res.status;
  assign chunk_number_o    = res.idx;
  assign chunk_total_o     = res.cnt;
  assign batch_id_o        = res.batch;
  assign data_class_o      = res.cls;
  assign offset_in_class_o = res.offs;
  assign payload_length_o  = res.plen;
  assign bundle_complete_o = res.complete;
  assign bundle_bytes_o    = res.sum;
endmodule

// ===== hw/rtl/crsc_parser.sv =====
// Front part: captures header bytes, checks magic, version, root and frame size.
`timescale 1ns / 1ps
module crsc_parser #(
  parameter int unsigned MaxChunkBytes = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  output logic               byte_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               last_byte_i,
  input  logic               first_expected_i,
  output logic               frame_valid_o,
  input  logic               frame_ready_i,
  output crsc_pkg::frame_t   frame_o
);
  localparam int unsigned PosSat = crsc_pkg::HdrBytes + MaxChunkBytes + 1;
  localparam int unsigned PosW   = $clog2(PosSat + 1);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      hdr_q [crsc_pkg::ShiftBytes];
  logic [7:0]      root_q [32];
  logic            bad_q, bad_d, rmis_q, rmis_d;
  logic            take;
  logic            in_root;
  crsc_pkg::frame_t fr;
  logic [31:0]     len_f;
  logic [PosW:0]   flen;

  assign in_root = (pos_q >= PosW'(crsc_pkg::RootAt)) && (pos_q < PosW'(crsc_pkg::HdrBytes));
  // Hold all bytes while a frame summary waits, root bytes even as it is taken:
  // the bundle state they are judged against settles once the sequencer takes it.
  assign byte_ready_o = frame_valid_o ? (frame_ready_i && !in_root) : 1'b1;
  assign take = byte_valid_i && byte_ready_o;

  always_comb begin
    bad_d  = bad_q;
    rmis_d = rmis_q;
    case (pos_q)
      PosW'(0): if (data_byte_i != crsc_pkg::Magic0) bad_d = 1'b1;
      PosW'(1): if (data_byte_i != crsc_pkg::Magic1) bad_d = 1'b1;
      PosW'(2): if (data_byte_i != crsc_pkg::Magic2) bad_d = 1'b1;
      PosW'(3): if (data_byte_i != crsc_pkg::Magic3) bad_d = 1'b1;
      PosW'(4): if (data_byte_i != crsc_pkg::Version) bad_d = 1'b1;
      default: ;
    endcase
    if (in_root &&
        !first_expected_i && root_q[5'(pos_q - PosW'(crsc_pkg::RootAt))] != data_byte_i)
      rmis_d = 1'b1;
    pos_d = (pos_q < PosW'(PosSat)) ? pos_q + 1'b1 : pos_q;
  end

  // Assemble the frame summary from captured bytes plus this last byte.
  always_comb begin
    flen = {1'b0, pos_q} + 1'b1;
    fr.batch = {hdr_q[5], hdr_q[6], hdr_q[7], hdr_q[8], hdr_q[9], hdr_q[10],
                hdr_q[11], hdr_q[12]};
    fr.idx   = {hdr_q[13], hdr_q[14], hdr_q[15], hdr_q[16]};
    fr.cnt   = {hdr_q[17], hdr_q[18], hdr_q[19], hdr_q[20]};
    fr.cls   = hdr_q[21];
    fr.offs  = {hdr_q[22], hdr_q[23], hdr_q[24], hdr_q[25], hdr_q[26], hdr_q[27],
                hdr_q[28], hdr_q[29]};
    len_f    = {hdr_q[30], hdr_q[31], hdr_q[32], hdr_q[33]};
    fr.hdr_bad  = bad_d || (flen < (PosW+1)'(crsc_pkg::HdrBytes));
    fr.len_bad  = (len_f > 32'(MaxChunkBytes)) ||
                  (64'(flen) != 64'(crsc_pkg::HdrBytes) + 64'(len_f));
    fr.root_bad = rmis_d;
    fr.plen     = len_f[16:0];
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (pos_q < PosW'(crsc_pkg::ShiftBytes)) hdr_q[6'(pos_q)] <= data_byte_i;
      if (in_root && first_expected_i)
        root_q[5'(pos_q - PosW'(crsc_pkg::RootAt))] <= data_byte_i;
      if (last_byte_i) frame_o <= fr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      bad_q <= 1'b0;
      rmis_q <= 1'b0;
      frame_valid_o <= 1'b0;
    end else begin
      if (take && last_byte_i) frame_valid_o <= 1'b1;
      else if (frame_ready_i) frame_valid_o <= 1'b0;
      if (take) begin
        if (last_byte_i) begin
          pos_q <= '0;
          bad_q <= 1'b0;
          rmis_q <= 1'b0;
        end else begin
          pos_q <= pos_d;
          bad_q <= bad_d;
          rmis_q <= rmis_d;
        end
      end
    end
  end
endmodule

// ===== hw/rtl/crsc_sequencer.sv =====
// Back part: checks the chunk sequence and builds the result registers.
`timescale 1ns / 1ps
`include "chunk_response_stream_checker_macros.svh"
module crsc_sequencer #(
  parameter int unsigned MaxChunks  = 256,
  parameter int unsigned ClassCount = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              match_en_i,
  input  logic [63:0]       wanted_i,
  input  logic              frame_valid_i,
  output logic              frame_ready_o,
  input  crsc_pkg::frame_t  frame_i,
  output logic              first_expected_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output crsc_pkg::result_t res_o
);
  localparam int unsigned IdxW = $clog2(MaxChunks + 2);

  logic [IdxW-1:0] exp_q;
  logic [IdxW-1:0] cnt_q;
  logic [63:0]     batch_q;
  logic [24:0]     run_q;
  logic            take, bad, first;
  logic [25:0]     sum;
  logic [32:0]     nxt;
  crsc_pkg::result_t r;

  assign frame_ready_o = !res_valid_o || res_ready_i;
  assign take  = frame_valid_i && frame_ready_o;
  assign first = (exp_q == '0);
  // Root bytes are compared against the bundle root only while mid-bundle;
  // a pending frame blocks the parser from updating its view.
  assign first_expected_o = first;

  always_comb begin
    r   = '0;
    sum = {1'b0, run_q} + 26'(frame_i.plen);
    nxt = {1'b0, frame_i.idx} + 33'd1;
    if (first)
      bad = (frame_i.idx != '0) || (frame_i.cnt < 32'(ClassCount)) ||
            (frame_i.cnt > 32'(MaxChunks)) || (match_en_i && frame_i.batch != wanted_i);
    else
      bad = (frame_i.batch != batch_q) || (frame_i.idx != 32'(exp_q)) ||
            (frame_i.cnt != 32'(cnt_q)) || frame_i.root_bad;
    if (frame_i.hdr_bad) begin
      r.status = crsc_pkg::StHeader;
    end else begin
      r.idx = frame_i.idx; r.cnt = frame_i.cnt; r.batch = frame_i.batch;
      r.cls = frame_i.cls; r.offs = frame_i.offs;
      if (frame_i.len_bad) r.status = crsc_pkg::StLength;
      else if (bad) begin
        r.status = crsc_pkg::StSequence;
        r.plen = frame_i.plen;
      end else if (sum > 26'(crsc_pkg::SumMax)) r.status = crsc_pkg::StLength;
      else begin
        r.status = crsc_pkg::StOk;
        r.plen = frame_i.plen;
        r.sum = sum[24:0];
        r.complete = nxt >= 33'(first ? frame_i.cnt[IdxW-1:0] : cnt_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_o <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      cnt_q <= '0;
      batch_q <= '0;
      run_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (take) res_valid_o <= 1'b1;
      else if (res_ready_i) res_valid_o <= 1'b0;
      if (take) begin
        if (r.status != crsc_pkg::StOk || r.complete) begin
          exp_q <= '0;
          run_q <= '0;
        end else begin
          if (first) begin
            batch_q <= frame_i.batch;
            cnt_q <= frame_i.cnt[IdxW-1:0];
          end
          exp_q <= nxt[IdxW-1:0];
          run_q <= sum[24:0];
        end
      end
    end
  end

  `CRSC_ASSERT_IMP(a_ok_within_sum, clk_i, rst_ni,
    res_valid_o && res_o.status == crsc_pkg::StOk, res_o.sum >= 25'(res_o.plen),
    "ok result with sum below its own length")
  `CRSC_ASSERT_IMP(a_err_no_complete, clk_i, rst_ni,
    res_valid_o && res_o.status != crsc_pkg::StOk, !res_o.complete && res_o.sum == '0,
    "error result carries bundle progress")
  `CRSC_ASSERT_NEXT(a_err_restarts, clk_i, rst_ni,
    take && r.status != crsc_pkg::StOk, exp_q == '0 && run_q == '0,
    "error did not restart the sequence")
endmodule
